>>> rtl/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CFQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cfq assertion failed");

// next-cycle implication, disabled while in reset
`define CFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cfq assertion failed");

`endif

>>> rtl/cfq_pkg.sv
// types, register indexes and pilot thresholds for the charger fault qualifier
package cfq_pkg;

    localparam int CFG_IDX_W = 8;
    localparam int TEMP_PERIOD_MS = 4000;

    localparam logic [CFG_IDX_W-1:0] REG_OV_LIMIT   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UV_LIMIT   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OC_LIMIT   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AC_LIMIT   = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_HOLD  = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CURR_HOLD  = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVER    = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMIT = 8'd7;

    // raw pilot words at which each level begins
    localparam logic signed [15:0] PILOT_12V_MIN = 16'sd10039;
    localparam logic signed [15:0] PILOT_9V_MIN  = -16'sd14007;
    localparam logic signed [15:0] PILOT_6V_MIN  = -16'sd23346;

    typedef enum logic [1:0] {
        LVL_ERR = 2'd0,
        LVL_6V  = 2'd1,
        LVL_9V  = 2'd2,
        LVL_12V = 2'd3
    } t_level;

    typedef struct packed {
        logic [15:0]        over_voltage_limit;
        logic [15:0]        low_voltage_limit;
        logic [15:0]        over_current_limit;
        logic [15:0]        abnormal_current_limit;
        logic [15:0]        voltage_hold_ms;
        logic [15:0]        current_hold_ms;
        logic [15:0]        recover_ms;
        logic signed [15:0] temp_raw_limit;
    } t_cfg;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic [15:0]        line_voltage;
        logic [15:0]        line_current;
        logic signed [15:0] temp_raw;
        logic signed [15:0] pilot_raw;
        logic               meter_valid;
        logic               start_flag;
    } t_item;

    typedef struct packed {
        t_level pilot_level;
        logic   over_temp;
        logic   over_voltage;
        logic   under_voltage;
        logic   over_current;
        logic   abnormal_current;
        logic   meter_fault;
        logic   any_fault;
        logic   restart_request;
    } t_result;

    function automatic t_level pilot_classify(input logic signed [15:0] raw);
        t_level lvl;
        if (raw >= PILOT_12V_MIN) begin
            lvl = LVL_12V;
        end else if (raw >= PILOT_9V_MIN) begin
            lvl = LVL_9V;
        end else if (raw >= PILOT_6V_MIN) begin
            lvl = LVL_6V;
        end else begin
            lvl = LVL_ERR;
        end
        return lvl;
    endfunction

endpackage

>>> rtl/charger_fault_qualifier_unit.sv
// top level of the charger fault qualifier
//
// one input beat per sample tick carries the time, voltage, current, raw
// temperature and pilot words plus the meter-valid and start flags; each
// beat gives exactly one output beat with the pilot level, the six fault
// flags, their OR and a restart request pulse
// configuration registers are written through the cfg channel, which is
// always ready; write only while no tick is in flight
// latency: a beat taken at one edge shows on the output one cycle later,
// after the next edge, and can leave at the edge after that
// throughput: one beat per cycle, set by the single pass from the input
// register through the timer and latch logic into the result register
// a stalled receiver holds the result register; one more beat is taken into
// the input register, then o_in_ready drops until the result leaves
// reset (synchronous, active low) clears both stages, all timers and
// latches, and loads the default limits
module charger_fault_qualifier_unit
    import cfq_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [31:0]          i_now_ms,
    input  logic [15:0]          i_line_voltage,
    input  logic [15:0]          i_line_current,
    input  logic signed [15:0]   i_temp_raw,
    input  logic signed [15:0]   i_pilot_raw,
    input  logic                 i_meter_valid,
    input  logic                 i_start_flag,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_pilot_level,
    output logic                 o_over_temp,
    output logic                 o_over_voltage,
    output logic                 o_under_voltage,
    output logic                 o_over_current,
    output logic                 o_abnormal_current,
    output logic                 o_meter_fault,
    output logic                 o_any_fault,
    output logic                 o_restart_request
);

    t_cfg    w_cfg;
    t_result w_result;
    logic    w_adv;
    logic    w_in_take;

    logic    r_in_vld,  n_in_vld;
    logic    r_out_vld, n_out_vld;
    t_item   r_in;
    t_result r_out;

    assign o_cfg_ready = 1'b1;

    cfq_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    cfq_fault_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_fault_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_cfg    (w_cfg),
        .i_item   (r_in),
        .o_result (w_result)
    );

    assign w_adv      = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_adv;
    assign w_in_take  = i_in_valid && o_in_ready;

    always_comb begin
        n_in_vld = r_in_vld;
        if (w_in_take) begin
            n_in_vld = 1'b1;
        end else if (w_adv) begin
            n_in_vld = 1'b0;
        end

        n_out_vld = r_out_vld;
        if (w_adv) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in.now_ms       <= i_now_ms;
            r_in.line_voltage <= i_line_voltage;
            r_in.line_current <= i_line_current;
            r_in.temp_raw     <= i_temp_raw;
            r_in.pilot_raw    <= i_pilot_raw;
            r_in.meter_valid  <= i_meter_valid;
            r_in.start_flag   <= i_start_flag;
        end
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_pilot_level      = r_out.pilot_level;
    assign o_over_temp        = r_out.over_temp;
    assign o_over_voltage     = r_out.over_voltage;
    assign o_under_voltage    = r_out.under_voltage;
    assign o_over_current     = r_out.over_current;
    assign o_abnormal_current = r_out.abnormal_current;
    assign o_meter_fault      = r_out.meter_fault;
    assign o_any_fault        = r_out.any_fault;
    assign o_restart_request  = r_out.restart_request;

endmodule

>>> rtl/cfq_cfg_regs.sv
// configuration register file for the charger fault qualifier
module cfq_cfg_regs
    import cfq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_OV_LIMIT:   n_cfg.over_voltage_limit     = i_cfg_data;
                REG_UV_LIMIT:   n_cfg.low_voltage_limit      = i_cfg_data;
                REG_OC_LIMIT:   n_cfg.over_current_limit     = i_cfg_data;
                REG_AC_LIMIT:   n_cfg.abnormal_current_limit = i_cfg_data;
                REG_VOLT_HOLD:  n_cfg.voltage_hold_ms        = i_cfg_data;
                REG_CURR_HOLD:  n_cfg.current_hold_ms        = i_cfg_data;
                REG_RECOVER:    n_cfg.recover_ms             = i_cfg_data;
                REG_TEMP_LIMIT: n_cfg.temp_raw_limit         = i_cfg_data;
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.over_voltage_limit     <= 16'd2640;
            r_cfg.low_voltage_limit      <= 16'd1760;
            r_cfg.over_current_limit     <= 16'd35000;
            r_cfg.abnormal_current_limit <= 16'd40000;
            r_cfg.voltage_hold_ms        <= 16'd5000;
            r_cfg.current_hold_ms        <= 16'd2000;
            r_cfg.recover_ms             <= 16'd3000;
            r_cfg.temp_raw_limit         <= -16'sd18577;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/cfq_fault_core.sv
// fault timers, latches and result logic for one tick
module cfq_fault_core
    import cfq_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    output t_result o_result
);

    localparam int TW = TIME_WIDTH;
    localparam int F_OT = 0;
    localparam int F_OV = 1;
    localparam int F_UV = 2;
    localparam int F_OC = 3;
    localparam int F_AC = 4;
    localparam int F_MF = 5;

    logic [TW-1:0] w_now;
    logic [TW-1:0] w_temp_el;
    logic [TW-1:0] w_ov_el;
    logic [TW-1:0] w_uv_el;
    logic [TW-1:0] w_oc_el;
    logic [TW-1:0] w_deadline;
    logic [TW-1:0] w_volt_hold;
    logic [TW-1:0] w_curr_hold;
    t_level        w_level;

    logic [TW-1:0] r_temp_time, n_temp_time;
    logic [TW-1:0] r_ov_since,  n_ov_since;
    logic [TW-1:0] r_uv_since,  n_uv_since;
    logic [TW-1:0] r_oc_since,  n_oc_since;
    logic [TW-1:0] r_recover,   n_recover;
    logic [5:0]    r_latch,     n_latch;
    logic          n_restart;

    assign w_now       = TW'(i_item.now_ms);
    assign w_temp_el   = w_now - r_temp_time;
    assign w_ov_el     = w_now - r_ov_since;
    assign w_uv_el     = w_now - r_uv_since;
    assign w_oc_el     = w_now - r_oc_since;
    assign w_deadline  = w_now + TW'(i_cfg.recover_ms);
    assign w_volt_hold = TW'(i_cfg.voltage_hold_ms);
    assign w_curr_hold = TW'(i_cfg.current_hold_ms);
    assign w_level     = pilot_classify(i_item.pilot_raw);

    always_comb begin
        n_temp_time = r_temp_time;
        n_ov_since  = r_ov_since;
        n_uv_since  = r_uv_since;
        n_oc_since  = r_oc_since;
        n_recover   = r_recover;
        n_latch     = r_latch;
        n_restart   = 1'b0;

        if (w_temp_el >= TW'(TEMP_PERIOD_MS)) begin
            n_temp_time = w_now;
            if (i_item.temp_raw <= i_cfg.temp_raw_limit) begin
                n_latch[F_OT] = 1'b1;
            end
        end

        if (i_item.meter_valid) begin
            n_latch[F_MF] = 1'b0;

            if (i_item.line_voltage >= i_cfg.over_voltage_limit) begin
                if (w_ov_el > w_volt_hold) begin
                    n_latch[F_OV] = 1'b1;
                    n_recover     = w_deadline;
                end
            end else begin
                n_ov_since = w_now;
            end

            if (i_item.line_voltage <= i_cfg.low_voltage_limit) begin
                if (w_uv_el > w_volt_hold) begin
                    n_latch[F_UV] = 1'b1;
                    n_recover     = w_deadline;
                end
            end else begin
                n_uv_since = w_now;
            end

            if (i_item.line_current >= i_cfg.over_current_limit) begin
                if (w_oc_el > w_curr_hold) begin
                    n_latch[F_OC] = 1'b1;
                    if (i_item.line_current >= i_cfg.abnormal_current_limit) begin
                        n_latch[F_AC] = 1'b1;
                    end
                end
            end else begin
                n_oc_since = w_now;
            end

            // in band excludes any voltage latch this tick, so the old deadline is safe
            if (i_item.line_voltage > i_cfg.low_voltage_limit
                && i_item.line_voltage < i_cfg.over_voltage_limit
                && w_now > r_recover) begin
                n_latch[F_OV] = 1'b0;
                n_latch[F_UV] = 1'b0;
                if ((w_level == LVL_9V || w_level == LVL_6V) && i_item.start_flag) begin
                    n_restart = 1'b1;
                end
            end
        end else begin
            n_latch[F_MF] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_time <= '0;
            r_ov_since  <= '0;
            r_uv_since  <= '0;
            r_oc_since  <= '0;
            r_recover   <= '0;
            r_latch     <= '0;
        end else if (i_en) begin
            r_temp_time <= n_temp_time;
            r_ov_since  <= n_ov_since;
            r_uv_since  <= n_uv_since;
            r_oc_since  <= n_oc_since;
            r_recover   <= n_recover;
            r_latch     <= n_latch;
        end
    end

    always_comb begin
        o_result.pilot_level      = w_level;
        o_result.over_temp        = n_latch[F_OT];
        o_result.over_voltage     = n_latch[F_OV];
        o_result.under_voltage    = n_latch[F_UV];
        o_result.over_current     = n_latch[F_OC];
        o_result.abnormal_current = n_latch[F_AC];
        o_result.meter_fault      = n_latch[F_MF];
        o_result.any_fault        = |n_latch;
        o_result.restart_request  = n_restart;
    end

endmodule

>>> rtl/cfq_checker.sv
// port-level checker for the charger fault qualifier and its bind
`include "assert_macros.svh"

module cfq_checker
    import cfq_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [1:0]           o_pilot_level,
    input logic                 o_over_temp,
    input logic                 o_over_voltage,
    input logic                 o_under_voltage,
    input logic                 o_over_current,
    input logic                 o_abnormal_current,
    input logic                 o_meter_fault,
    input logic                 o_any_fault,
    input logic                 o_restart_request
);

    `CFQ_ASSERT_NOW(a_any_fault_or, i_clk, i_rst_n, o_out_valid,
        o_any_fault == (o_over_temp | o_over_voltage | o_under_voltage
                        | o_over_current | o_abnormal_current | o_meter_fault))

    `CFQ_ASSERT_NOW(a_restart_clean, i_clk, i_rst_n, o_out_valid && o_restart_request,
        !o_over_voltage && !o_under_voltage && !o_meter_fault
        && (o_pilot_level == LVL_6V || o_pilot_level == LVL_9V))

    `CFQ_ASSERT_NOW(a_abnormal_needs_oc, i_clk, i_rst_n, o_out_valid && o_abnormal_current,
        o_over_current)

    `CFQ_ASSERT_NEXT(a_oc_sticky, i_clk, i_rst_n, o_out_valid && i_out_ready && o_over_current,
        !o_out_valid || o_over_current)

    `CFQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

endmodule

bind charger_fault_qualifier_unit cfq_checker u_cfq_checker (.*);

>>> bench/fault_flag_checker.sv
// fault qualifier checker: mirrors the timers and latches and compares every output beat
module fault_flag_checker
    import cfq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [31:0]          i_now_ms,
    input  logic [15:0]          i_line_voltage,
    input  logic [15:0]          i_line_current,
    input  logic signed [15:0]   i_temp_raw,
    input  logic signed [15:0]   i_pilot_raw,
    input  logic                 i_meter_valid,
    input  logic                 i_start_flag,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [1:0]           i_pilot_level,
    input  logic                 i_over_temp,
    input  logic                 i_over_voltage,
    input  logic                 i_under_voltage,
    input  logic                 i_over_current,
    input  logic                 i_abnormal_current,
    input  logic                 i_meter_fault,
    input  logic                 i_any_fault,
    input  logic                 i_restart_request,
    output int                   o_pending,
    output int                   o_fail_count
);

    localparam t_cfg LIMITS_AT_RESET = '{
        16'd2640, 16'd1760, 16'd35000, 16'd40000,
        16'd5000, 16'd2000, 16'd3000, -16'sd18577
    };

    t_cfg        limits = LIMITS_AT_RESET;
    logic [31:0] temp_checked_at = '0;
    logic [31:0] ov_since = '0;
    logic [31:0] uv_since = '0;
    logic [31:0] oc_since = '0;
    logic [31:0] recover_at = '0;
    logic        ot_latch = 1'b0;
    logic        ov_latch = 1'b0;
    logic        uv_latch = 1'b0;
    logic        oc_latch = 1'b0;
    logic        ac_latch = 1'b0;
    logic        mf_latch = 1'b0;
    t_result     flags_q[$];
    int          fails = 0;

    function automatic t_result qualify_tick(input t_item it);
        t_result     r;
        longint      pilot_scaled;
        logic [31:0] now;
        logic [31:0] held;
        r = '0;
        now = it.now_ms;

        // pilot millivolts scaled by 1e5 to stay in integers
        pilot_scaled = 64'sd1285 * longint'($signed(it.pilot_raw)) + 64'sd42100000;
        if (pilot_scaled >= 64'sd55000000) begin
            r.pilot_level = LVL_12V;
        end else if (pilot_scaled >= 64'sd24100000) begin
            r.pilot_level = LVL_9V;
        end else if (pilot_scaled >= 64'sd12100000) begin
            r.pilot_level = LVL_6V;
        end else begin
            r.pilot_level = LVL_ERR;
        end

        held = now - temp_checked_at;
        if (held >= 32'(TEMP_PERIOD_MS)) begin
            temp_checked_at = now;
            if ($signed(it.temp_raw) <= $signed(limits.temp_raw_limit)) begin
                ot_latch = 1'b1;
            end
        end

        if (it.meter_valid) begin
            mf_latch = 1'b0;

            if (it.line_voltage >= limits.over_voltage_limit) begin
                held = now - ov_since;
                if (held > 32'(limits.voltage_hold_ms)) begin
                    ov_latch = 1'b1;
                    recover_at = now + 32'(limits.recover_ms);
                end
            end else begin
                ov_since = now;
            end

            if (it.line_voltage <= limits.low_voltage_limit) begin
                held = now - uv_since;
                if (held > 32'(limits.voltage_hold_ms)) begin
                    uv_latch = 1'b1;
                    recover_at = now + 32'(limits.recover_ms);
                end
            end else begin
                uv_since = now;
            end

            if (it.line_current >= limits.over_current_limit) begin
                held = now - oc_since;
                if (held > 32'(limits.current_hold_ms)) begin
                    oc_latch = 1'b1;
                    if (it.line_current >= limits.abnormal_current_limit) begin
                        ac_latch = 1'b1;
                    end
                end
            end else begin
                oc_since = now;
            end

            // back in band after deadline: voltage faults clear, restart may be flagged
            if (it.line_voltage > limits.low_voltage_limit &&
                it.line_voltage < limits.over_voltage_limit && now > recover_at) begin
                ov_latch = 1'b0;
                uv_latch = 1'b0;
                if ((r.pilot_level == LVL_9V || r.pilot_level == LVL_6V) && it.start_flag) begin
                    r.restart_request = 1'b1;
                end
            end
        end else begin
            mf_latch = 1'b1;
        end

        r.over_temp        = ot_latch;
        r.over_voltage     = ov_latch;
        r.under_voltage    = uv_latch;
        r.over_current     = oc_latch;
        r.abnormal_current = ac_latch;
        r.meter_fault      = mf_latch;
        r.any_fault        = ot_latch | ov_latch | uv_latch | oc_latch | ac_latch | mf_latch;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_item   tick;
        t_result want;
        if (!i_rst_n) begin
            limits = LIMITS_AT_RESET;
            temp_checked_at = '0;
            ov_since = '0;
            uv_since = '0;
            oc_since = '0;
            recover_at = '0;
            {ot_latch, ov_latch, uv_latch, oc_latch, ac_latch, mf_latch} = '0;
            flags_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_OV_LIMIT:   limits.over_voltage_limit = i_cfg_data;
                    REG_UV_LIMIT:   limits.low_voltage_limit = i_cfg_data;
                    REG_OC_LIMIT:   limits.over_current_limit = i_cfg_data;
                    REG_AC_LIMIT:   limits.abnormal_current_limit = i_cfg_data;
                    REG_VOLT_HOLD:  limits.voltage_hold_ms = i_cfg_data;
                    REG_CURR_HOLD:  limits.current_hold_ms = i_cfg_data;
                    REG_RECOVER:    limits.recover_ms = i_cfg_data;
                    REG_TEMP_LIMIT: limits.temp_raw_limit = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_in_valid && i_in_ready) begin
                tick.now_ms       = i_now_ms;
                tick.line_voltage = i_line_voltage;
                tick.line_current = i_line_current;
                tick.temp_raw     = i_temp_raw;
                tick.pilot_raw    = i_pilot_raw;
                tick.meter_valid  = i_meter_valid;
                tick.start_flag   = i_start_flag;
                flags_q.push_back(qualify_tick(tick));
            end

            if (i_out_valid && i_out_ready) begin
                if (flags_q.size() == 0) begin
                    $error("output beat with no tick outstanding");
                    fails++;
                end else begin
                    want = flags_q.pop_front();
                    check_field("pilot_level", want.pilot_level, i_pilot_level);
                    check_field("over_temp", want.over_temp, i_over_temp);
                    check_field("over_voltage", want.over_voltage, i_over_voltage);
                    check_field("under_voltage", want.under_voltage, i_under_voltage);
                    check_field("over_current", want.over_current, i_over_current);
                    check_field("abnormal_current", want.abnormal_current,
                                i_abnormal_current);
                    check_field("meter_fault", want.meter_fault, i_meter_fault);
                    check_field("any_fault", want.any_fault, i_any_fault);
                    check_field("restart_request", want.restart_request, i_restart_request);
                end
            end
        end
        o_pending    <= flags_q.size();
        o_fail_count <= fails;
    end

endmodule

>>> bench/charger_fault_qualifier_unit_tb.sv
// testbench top for the charger fault qualifier: tick stimulus, settings phases and verdict
module charger_fault_qualifier_unit_tb;
    import cfq_pkg::*;

    localparam int PHASES          = 8;
    localparam int TICKS_PER_PHASE = 155;
    localparam int CYCLE_LIMIT     = 300000;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [15:0]          i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [31:0]          i_now_ms = '0;
    logic [15:0]          i_line_voltage = '0;
    logic [15:0]          i_line_current = '0;
    logic signed [15:0]   i_temp_raw = '0;
    logic signed [15:0]   i_pilot_raw = '0;
    logic                 i_meter_valid = 1'b0;
    logic                 i_start_flag = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b1;
    logic [1:0]           o_pilot_level;
    logic                 o_over_temp;
    logic                 o_over_voltage;
    logic                 o_under_voltage;
    logic                 o_over_current;
    logic                 o_abnormal_current;
    logic                 o_meter_fault;
    logic                 o_any_fault;
    logic                 o_restart_request;

    int                   pending;
    int                   fail_count;
    int unsigned          cycle_count = 0;
    int                   stall_left = 0;
    logic                 idling_on = 1'b1;
    logic [31:0]          t_ms = '0;

    charger_fault_qualifier_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_now_ms           (i_now_ms),
        .i_line_voltage     (i_line_voltage),
        .i_line_current     (i_line_current),
        .i_temp_raw         (i_temp_raw),
        .i_pilot_raw        (i_pilot_raw),
        .i_meter_valid      (i_meter_valid),
        .i_start_flag       (i_start_flag),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_pilot_level      (o_pilot_level),
        .o_over_temp        (o_over_temp),
        .o_over_voltage     (o_over_voltage),
        .o_under_voltage    (o_under_voltage),
        .o_over_current     (o_over_current),
        .o_abnormal_current (o_abnormal_current),
        .o_meter_fault      (o_meter_fault),
        .o_any_fault        (o_any_fault),
        .o_restart_request  (o_restart_request)
    );

    fault_flag_checker checker_i (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .i_in_ready         (o_in_ready),
        .i_now_ms           (i_now_ms),
        .i_line_voltage     (i_line_voltage),
        .i_line_current     (i_line_current),
        .i_temp_raw         (i_temp_raw),
        .i_pilot_raw        (i_pilot_raw),
        .i_meter_valid      (i_meter_valid),
        .i_start_flag       (i_start_flag),
        .i_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .i_pilot_level      (o_pilot_level),
        .i_over_temp        (o_over_temp),
        .i_over_voltage     (o_over_voltage),
        .i_under_voltage    (o_under_voltage),
        .i_over_current     (o_over_current),
        .i_abnormal_current (o_abnormal_current),
        .i_meter_fault      (o_meter_fault),
        .i_any_fault        (o_any_fault),
        .i_restart_request  (o_restart_request),
        .o_pending          (pending),
        .o_fail_count       (fail_count)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // receiver back-pressure in bursts
    always @(posedge i_clk) begin
        if (!idling_on) begin
            i_out_ready <= 1'b1;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) begin
                stall_left <= $urandom_range(1, 15);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("charger_fault_qualifier_unit_tb failed");
            $finish;
        end
    end

    function automatic int pick(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    task automatic send_tick(input logic [31:0] now, input int volt, input int curr,
                             input int temp, input int pilot, input logic valid,
                             input logic start);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_now_ms       <= now;
        i_line_voltage <= 16'(volt);
        i_line_current <= 16'(curr);
        i_temp_raw     <= 16'(temp);
        i_pilot_raw    <= 16'(pilot);
        i_meter_valid  <= valid;
        i_start_flag   <= start;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // stop sending, let every result out, then give the pipeline time to empty
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_settings(input t_cfg c);
        logic [CFG_IDX_W-1:0] idx;
        logic [15:0]          word;
        for (int r = 0; r <= int'(REG_TEMP_LIMIT) + 1; r++) begin
            idx = CFG_IDX_W'(r);
            case (idx)
                REG_OV_LIMIT:   word = c.over_voltage_limit;
                REG_UV_LIMIT:   word = c.low_voltage_limit;
                REG_OC_LIMIT:   word = c.over_current_limit;
                REG_AC_LIMIT:   word = c.abnormal_current_limit;
                REG_VOLT_HOLD:  word = c.voltage_hold_ms;
                REG_CURR_HOLD:  word = c.current_hold_ms;
                REG_RECOVER:    word = c.recover_ms;
                REG_TEMP_LIMIT: word = c.temp_raw_limit;
                default: begin
                    // unmapped index, must be ignored
                    idx  = CFG_IDX_W'(pick(int'(REG_TEMP_LIMIT) + 1, (1 << CFG_IDX_W) - 1));
                    word = 16'($urandom);
                end
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= word;
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_cfg random_settings(input logic any_temp);
        t_cfg c;
        c.over_voltage_limit     = 16'(pick(2000, 3000));
        c.low_voltage_limit      = 16'(pick(1000, 2000));
        c.over_current_limit     = 16'(pick(20000, 40000));
        c.abnormal_current_limit = 16'(pick(30000, 65535));
        c.voltage_hold_ms        = 16'(pick(0, 3000));
        c.current_hold_ms        = 16'(pick(0, 3000));
        c.recover_ms             = 16'(pick(0, 3000));
        c.temp_raw_limit         = any_temp ? 16'(pick(-32768, 32767)) : -16'sd18577;
        return c;
    endfunction

    // mostly persistent voltage, current and pilot conditions on a rising time base
    task automatic send_random_ticks(input int count, input t_cfg c, input int step_ms,
                                     input int temp_low_pct, input logic mid_drain);
        int v_mode;
        int c_mode;
        int p_mode;
        int ovl;
        int uvl;
        int ocl;
        int acl;
        int tl;
        int volt;
        int curr;
        int temp;
        int pilot;
        ovl = c.over_voltage_limit;
        uvl = c.low_voltage_limit;
        ocl = c.over_current_limit;
        acl = c.abnormal_current_limit;
        tl  = $signed(c.temp_raw_limit);
        v_mode = 0;
        c_mode = 0;
        p_mode = 2;
        for (int n = 0; n < count; n++) begin
            if (mid_drain && n == count / 2) begin
                wait_drained();
            end
            if ($urandom_range(0, 7) == 0) v_mode = pick(0, 9);
            if ($urandom_range(0, 7) == 0) c_mode = pick(0, 3);
            if ($urandom_range(0, 7) == 0) p_mode = pick(0, 4);

            if (v_mode < 4 && uvl + 1 <= ovl - 1) begin
                volt = pick(uvl + 1, ovl - 1);
            end else if (v_mode < 6) begin
                volt = pick(ovl, 65535);
            end else if (v_mode < 8) begin
                volt = pick(0, uvl);
            end else begin
                volt = pick(0, 65535);
            end

            case (c_mode)
                0:       curr = (ocl > 0) ? pick(0, ocl - 1) : pick(0, 65535);
                1:       curr = (acl > ocl) ? pick(ocl, acl - 1) : pick(ocl, 65535);
                2:       curr = pick((acl > ocl) ? acl : ocl, 65535);
                default: curr = pick(0, 65535);
            endcase

            case (p_mode)
                0:       pilot = pick(-32768, int'(PILOT_6V_MIN) - 1);
                1:       pilot = pick(PILOT_6V_MIN, int'(PILOT_9V_MIN) - 1);
                2:       pilot = pick(PILOT_9V_MIN, int'(PILOT_12V_MIN) - 1);
                3:       pilot = pick(PILOT_12V_MIN, 32767);
                default: pilot = pick(-32768, 32767);
            endcase

            if (tl < 32767 && pick(0, 99) >= temp_low_pct) begin
                temp = pick(tl + 1, 32767);
            end else begin
                temp = pick(-32768, tl);
            end

            // occasional jump anywhere on the time base
            if ($urandom_range(0, 59) == 0) begin
                t_ms = $urandom;
            end else begin
                t_ms = t_ms + 32'(pick(0, step_ms));
            end

            send_tick(t_ms, volt, curr, temp, pilot, pick(0, 19) != 0, 1'($urandom));
        end
    endtask

    initial begin
        t_cfg limits;
        int   step_ms;
        int   temp_low_pct;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // field extremes, pilot boundaries, meter invalid, time wrap
        send_tick(32'hFFFF_FFFF, 2200, 0, 32767, 32767, 1'b1, 1'b0);
        send_tick(32'd0, 0, 0, -32768, -32768, 1'b1, 1'b0);
        send_tick(32'd10, 65535, 65535, 0, PILOT_12V_MIN, 1'b1, 1'b0);
        send_tick(32'd20, 1760, 34999, -1, int'(PILOT_12V_MIN) - 1, 1'b0, 1'b1);
        send_tick(32'd30, 1761, 35000, 100, PILOT_9V_MIN, 1'b1, 1'b1);
        send_tick(32'd40, 2639, 0, 100, int'(PILOT_9V_MIN) - 1, 1'b1, 1'b1);
        send_tick(32'd50, 2640, 0, 100, PILOT_6V_MIN, 1'b1, 1'b1);
        send_tick(32'd60, 2200, 0, 100, int'(PILOT_6V_MIN) - 1, 1'b1, 1'b1);
        // under-voltage persists, latches, then recovers with a restart
        send_tick(32'd100, 1000, 0, 100, 0, 1'b1, 1'b0);
        send_tick(32'd2100, 1000, 0, 100, 0, 1'b1, 1'b0);
        send_tick(32'd4100, 1000, 0, 100, 0, 1'b1, 1'b0);
        send_tick(32'd5200, 1000, 0, 100, 0, 1'b1, 1'b1);
        send_tick(32'd6000, 2200, 0, 100, 0, 1'b1, 1'b1);
        send_tick(32'd8201, 2200, 0, 100, 0, 1'b1, 1'b1);
        // over-voltage latch and recovery on a six volt pilot
        send_tick(32'd9000, 3000, 0, 100, -20000, 1'b1, 1'b1);
        send_tick(32'd14001, 3000, 0, 100, -20000, 1'b1, 1'b1);
        send_tick(32'd17002, 2200, 0, 100, -20000, 1'b1, 1'b1);
        // over-current across a meter-invalid beat
        send_tick(32'd17100, 2200, 36000, 100, 0, 1'b1, 1'b0);
        send_tick(32'd18000, 2200, 36000, 100, 0, 1'b0, 1'b0);
        send_tick(32'd19200, 2200, 36000, 100, 0, 1'b1, 1'b0);
        t_ms = 32'd19200;

        for (int p = 0; p < PHASES; p++) begin
            step_ms      = 1500;
            temp_low_pct = 3;
            case (p)
                0: begin
                    limits = '{16'd2640, 16'd1760, 16'd35000, 16'd65535,
                               16'd500, 16'd300, 16'd400, -16'sd32768};
                    step_ms      = 250;
                    temp_low_pct = 0;
                end
                1: begin
                    limits = '{16'd65535, 16'd0, 16'd65535, 16'd65535,
                               16'd65535, 16'd65535, 16'd65535, -16'sd32768};
                    step_ms      = 30000;
                    temp_low_pct = 0;
                end
                2: begin
                    limits = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, -16'sd18577};
                    step_ms      = 100;
                    temp_low_pct = 0;
                end
                5: limits = random_settings(1'b1);
                6: begin
                    limits = '{16'd2640, 16'd1760, 16'd35000, 16'd40000,
                               16'd5000, 16'd2000, 16'd3000, -16'sd18577};
                    step_ms = 2500;
                end
                default: limits = random_settings(1'b0);
            endcase
            // start the time base just below the wrap
            if (p == 4) begin
                t_ms = 32'hFFFE_0000;
            end
            wait_drained();
            idling_on = !(p == 3 || p == PHASES - 1);
            write_settings(limits);
            send_random_ticks(TICKS_PER_PHASE, limits, step_ms, temp_low_pct, p == 2);
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("charger_fault_qualifier_unit_tb passed");
        end else begin
            $display("charger_fault_qualifier_unit_tb failed");
        end
        $finish;
    end

endmodule
